[rtl/core/calibrated_levitation_p_controller_assert.svh]
// Assertion macros used by the checker file of the levitation controller.
`ifndef CALIBRATED_LEVITATION_P_CONTROLLER_ASSERT_SVH
`define CALIBRATED_LEVITATION_P_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clpc assertion failed");

`endif

[rtl/core/clpc_pkg.sv]
package clpc_pkg;

  localparam int RING_DEPTH    = 8;
  localparam int TABLE_ENTRIES = 32;
  localparam int PWM_TOP       = 400;
  localparam int PWM_MIN_DRIVE = PWM_TOP / 100;
  localparam int PWM_QUARTER   = PWM_TOP / 4;

  localparam int SAMPLE_W    = 10;
  localparam int PWM_W       = 9;
  localparam int ERR_W       = 12;
  localparam int OFFSET_W    = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_DIFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

  localparam logic [7:0]  GAIN_SCALE_RST  = 8'd50;
  localparam logic [9:0]  DWELL_COUNT_RST = 10'd100;
  localparam logic [7:0]  TICK_DIVIDE_RST = 8'd11;
  localparam logic [10:0] TRIP_DIFF_RST   = 11'h7BA;
  localparam logic [6:0]  DRIVE_LIMIT_RST = 7'd80;

  typedef enum logic [1:0] {
    CMD_UPPER = 2'd0,
    CMD_LOWER = 2'd1,
    CMD_GAIN  = 2'd2,
    CMD_TICK  = 2'd3
  } command_t;

  typedef struct packed {
    command_t              command;
    logic [SAMPLE_W-1:0]   sample;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0]        pwm_compare;
    logic                    levitating;
    logic signed [ERR_W-1:0] error_value;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic ring;
    logic tick;
    logic cal;
    logic lev_mul;
    logic lev_idx;
    logic lev_err;
    logic lev_nv;
    logic lev_drive;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic levitating;
    logic tick_fire;
  } dp_stat_t;

endpackage

[rtl/core/calibrated_levitation_p_controller.sv]
// Channel   Direction  Handshake                  Payload
// cmd       in         cmd_valid / cmd_ready      cmd_data (command, sample)
// result    out        result_valid / result_ready result_data (pwm, mode, error)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A sensor sample passes the ring update and output states. A timer tick while
// calibrating passes the tick state, and also the calibration state when the prescaler
// fires. A gain sample while calibrating or a tick while levitating goes straight to the
// output state. A gain sample in levitate mode passes the multiply, index, offset table
// read, error, drive product, update and output steps of the datapath.
// Reset is synchronous; the offset table is not cleared and needs no sweep.
// A new request is accepted while the previous result waits in the output
// register; a third request waits until that result is taken.
module calibrated_levitation_p_controller #(
  parameter int TABLE_ENTRIES = clpc_pkg::TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  clpc_pkg::in_item_t              cmd_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output clpc_pkg::out_item_t             result_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  clpc_pkg::dp_cmd_t  dp_cmd;
  clpc_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  clpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (cmd_data.command),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .dp_cmd       (dp_cmd)
  );

  clpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_data    (cmd_data),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dp_cmd      (dp_cmd),
    .stat        (stat),
    .result_data (result_data)
  );

endmodule

[rtl/core/clpc_ctrl.sv]
module clpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  clpc_pkg::command_t command,
  output logic               result_valid,
  input  logic               result_ready,
  input  clpc_pkg::dp_stat_t stat,
  output clpc_pkg::dp_cmd_t  dp_cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RING,
    S_TICK,
    S_CAL,
    S_MUL,
    S_IDX,
    S_READ,
    S_ERR,
    S_NV,
    S_DRIVE,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmd_ready    <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cmd_ready <= 1'b0;
            case (command)
              clpc_pkg::CMD_UPPER: state <= S_RING;
              clpc_pkg::CMD_LOWER: state <= S_RING;
              clpc_pkg::CMD_GAIN:  state <= stat.levitating ? S_MUL : S_DONE;
              clpc_pkg::CMD_TICK:  state <= stat.levitating ? S_DONE : S_TICK;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_RING:  state <= S_DONE;
        S_TICK:  state <= stat.tick_fire ? S_CAL : S_DONE;
        S_CAL:   state <= S_DONE;
        S_MUL:   state <= S_IDX;
        S_IDX:   state <= S_READ;
        S_READ:  state <= S_ERR;
        S_ERR:   state <= S_NV;
        S_NV:    state <= S_DRIVE;
        S_DRIVE: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            cmd_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    dp_cmd           = '0;
    dp_cmd.capture   = (state == S_IDLE) && cmd_valid && cmd_ready;
    dp_cmd.ring      = (state == S_RING);
    dp_cmd.tick      = (state == S_TICK);
    dp_cmd.cal       = (state == S_CAL);
    dp_cmd.lev_mul   = (state == S_MUL);
    dp_cmd.lev_idx   = (state == S_IDX);
    dp_cmd.lev_err   = (state == S_ERR);
    dp_cmd.lev_nv    = (state == S_NV);
    dp_cmd.lev_drive = (state == S_DRIVE);
    dp_cmd.load_out  = (state == S_DONE) && out_free;
  end

endmodule

[rtl/core/clpc_dp.sv]
module clpc_dp #(
  parameter int TABLE_ENTRIES = clpc_pkg::TABLE_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  clpc_pkg::in_item_t                  cmd_data,
  input  logic                                cfg_we,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  clpc_pkg::dp_cmd_t                   dp_cmd,
  output clpc_pkg::dp_stat_t                  stat,
  output clpc_pkg::out_item_t                 result_data
);

  localparam int PTR_W        = $clog2(clpc_pkg::RING_DEPTH);
  localparam int SUM_W        = clpc_pkg::SAMPLE_W + PTR_W;
  localparam int IDX_W        = $clog2(TABLE_ENTRIES);
  localparam int TI_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CAL_STEP_RAW = (clpc_pkg::PWM_TOP * 6) / (10 * TABLE_ENTRIES);
  localparam int CAL_STEP     = (CAL_STEP_RAW == 0) ? 1 : CAL_STEP_RAW;
  localparam int RECIP_SHIFT  = 16;
  localparam int RECIP        = (1 << RECIP_SHIFT) / CAL_STEP;
  localparam int QP_W         = clpc_pkg::PWM_W + RECIP_SHIFT + 1;
  localparam int PW           = clpc_pkg::PWM_W;
  localparam int EW           = clpc_pkg::ERR_W;
  localparam int OW           = clpc_pkg::OFFSET_W;
  localparam int NV_W         = 22;

  logic [7:0]         gain_scale;
  logic [9:0]         dwell_count;
  logic [7:0]         tick_divide;
  logic signed [10:0] trip_diff;
  logic [6:0]         drive_limit;

  clpc_pkg::command_t             cmd_q;
  logic [clpc_pkg::SAMPLE_W-1:0]  sample_q;

  logic [clpc_pkg::SAMPLE_W-1:0]  upper_ring [clpc_pkg::RING_DEPTH];
  logic [clpc_pkg::SAMPLE_W-1:0]  lower_ring [clpc_pkg::RING_DEPTH];
  logic [PTR_W-1:0]               upper_ptr;
  logic [PTR_W-1:0]               lower_ptr;
  logic [SUM_W-1:0]               upper_sum;
  logic [SUM_W-1:0]               lower_sum;

  logic signed [OW-1:0] offset_table [TABLE_ENTRIES];
  logic signed [OW-1:0] offset_rd;
  logic                 table_we;

  logic              levitate_mode;
  logic [9:0]        dwell_cnt;
  logic [TI_W-1:0]   table_index;
  logic [PW-1:0]     pwm_value;
  logic [7:0]        tick_prescale;
  logic signed [EW-1:0] last_error;

  logic [17:0]          kp_prod;
  logic [7:0]           kp;
  logic [PW-1:0]        q_est;
  logic [IDX_W-1:0]     idx;
  logic signed [NV_W-1:0] nv;

  logic [PTR_W-1:0]            upper_ptr_next;
  logic [PTR_W-1:0]            lower_ptr_next;
  logic [clpc_pkg::SAMPLE_W-1:0] upper_avg;
  logic [clpc_pkg::SAMPLE_W-1:0] lower_avg;
  logic signed [OW-1:0]        offset_now;
  logic [7:0]                  prescale_inc;
  logic                        tick_fire;
  logic [TI_W-1:0]             table_index_next;
  logic [15:0]                 cal_prod;
  logic [PW-1:0]               cal_pwm;
  logic [QP_W-1:0]             q_prod;
  logic [15:0]                 q_back;
  logic [15:0]                 q_rem;
  logic [PW:0]                 q_fix;
  logic signed [EW-1:0]        err_now;
  logic signed [EW:0]          neg_err;
  logic signed [NV_W-1:0]      nv_prod;
  logic                        trip_hit;
  logic                        nv_over;
  logic                        nv_zero;
  logic [15:0]                 drive_prod;
  logic [PW-1:0]               drive_pwm;

  assign upper_ptr_next = upper_ptr + 1'b1;
  assign lower_ptr_next = lower_ptr + 1'b1;
  assign upper_avg      = upper_sum[SUM_W-1:PTR_W];
  assign lower_avg      = lower_sum[SUM_W-1:PTR_W];
  assign offset_now     = $signed({1'b0, lower_avg}) - $signed({1'b0, upper_avg});

  assign prescale_inc = tick_prescale + 8'd1;
  assign tick_fire    = (prescale_inc >= tick_divide);

  assign table_index_next = table_index + 1'b1;
  assign cal_prod = 16'(table_index_next) * 16'(CAL_STEP);
  assign cal_pwm  = (cal_prod > 16'(clpc_pkg::PWM_TOP)) ? PW'(clpc_pkg::PWM_TOP)
                                                        : cal_prod[PW-1:0];
  assign table_we = dp_cmd.cal && (dwell_cnt >= dwell_count);

  assign q_prod = QP_W'(pwm_value) * QP_W'(RECIP);
  assign q_back = 16'(q_est) * 16'(CAL_STEP);
  assign q_rem  = 16'(pwm_value) - q_back;
  assign q_fix  = (PW + 1)'(q_est) + (PW + 1)'(q_rem >= 16'(CAL_STEP));

  assign err_now = EW'($signed({1'b0, lower_avg})) - EW'($signed({1'b0, upper_avg}))
                   - EW'(offset_rd);
  assign neg_err = -(EW + 1)'(last_error);
  assign nv_prod = NV_W'($signed({1'b0, kp})) * NV_W'(neg_err);

  assign trip_hit   = last_error < EW'(trip_diff);
  assign nv_over    = nv > $signed({15'b0, drive_limit});
  assign nv_zero    = nv[NV_W-1] || (nv == '0);
  assign drive_prod = 16'(nv[6:0]) * 16'(clpc_pkg::PWM_MIN_DRIVE);
  assign drive_pwm  = (drive_prod > 16'(clpc_pkg::PWM_TOP)) ? PW'(clpc_pkg::PWM_TOP)
                                                            : drive_prod[PW-1:0];

  assign stat.levitating = levitate_mode;
  assign stat.tick_fire  = tick_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_scale  <= clpc_pkg::GAIN_SCALE_RST;
      dwell_count <= clpc_pkg::DWELL_COUNT_RST;
      tick_divide <= clpc_pkg::TICK_DIVIDE_RST;
      trip_diff   <= $signed(clpc_pkg::TRIP_DIFF_RST);
      drive_limit <= clpc_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        clpc_pkg::REG_GAIN_SCALE:  gain_scale  <= cfg_data[7:0];
        clpc_pkg::REG_DWELL_COUNT: dwell_count <= cfg_data[9:0];
        clpc_pkg::REG_TICK_DIVIDE: tick_divide <= cfg_data[7:0];
        clpc_pkg::REG_TRIP_DIFF:   trip_diff   <= $signed(cfg_data[10:0]);
        clpc_pkg::REG_DRIVE_LIMIT: drive_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q    <= cmd_data.command;
      sample_q <= cmd_data.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < clpc_pkg::RING_DEPTH; i++) begin
        upper_ring[i] <= '0;
        lower_ring[i] <= '0;
      end
      upper_ptr <= '0;
      lower_ptr <= '0;
      upper_sum <= '0;
      lower_sum <= '0;
    end else if (dp_cmd.ring) begin
      if (cmd_q == clpc_pkg::CMD_UPPER) begin
        upper_ptr                  <= upper_ptr_next;
        upper_ring[upper_ptr_next] <= sample_q;
        upper_sum <= upper_sum + SUM_W'(sample_q) - SUM_W'(upper_ring[upper_ptr_next]);
      end else begin
        lower_ptr                  <= lower_ptr_next;
        lower_ring[lower_ptr_next] <= sample_q;
        lower_sum <= lower_sum + SUM_W'(sample_q) - SUM_W'(lower_ring[lower_ptr_next]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (table_we) begin
      offset_table[table_index[IDX_W-1:0]] <= offset_now;
    end
    offset_rd <= offset_table[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levitate_mode <= 1'b0;
      dwell_cnt     <= '0;
      table_index   <= '0;
      pwm_value     <= PW'(clpc_pkg::PWM_MIN_DRIVE);
      tick_prescale <= '0;
      last_error    <= '0;
    end else begin
      if (dp_cmd.tick) begin
        tick_prescale <= tick_fire ? 8'd0 : prescale_inc;
      end
      if (dp_cmd.cal) begin
        if (dwell_cnt >= dwell_count) begin
          table_index <= table_index_next;
          if (table_index_next >= TI_W'(TABLE_ENTRIES)) begin
            levitate_mode <= 1'b1;
            pwm_value     <= PW'(clpc_pkg::PWM_QUARTER);
          end else begin
            pwm_value <= cal_pwm;
            dwell_cnt <= '0;
          end
        end else begin
          dwell_cnt <= dwell_cnt + 10'd1;
        end
      end
      if (dp_cmd.lev_err) begin
        last_error <= err_now;
      end
      if (dp_cmd.lev_drive) begin
        if (trip_hit) begin
          pwm_value <= PW'(clpc_pkg::PWM_MIN_DRIVE);
        end else if (!nv_over) begin
          pwm_value <= nv_zero ? PW'(clpc_pkg::PWM_MIN_DRIVE) : drive_pwm;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.lev_mul) begin
      kp_prod <= 18'(gain_scale) * 18'(sample_q);
      q_est   <= q_prod[RECIP_SHIFT +: PW];
    end
    if (dp_cmd.lev_idx) begin
      kp  <= kp_prod[17:10];
      idx <= (q_fix >= (PW + 1)'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1)
                                                  : q_fix[IDX_W-1:0];
    end
    if (dp_cmd.lev_nv) begin
      nv <= nv_prod;
    end
    if (dp_cmd.load_out) begin
      result_data.pwm_compare <= pwm_value;
      result_data.levitating  <= levitate_mode;
      result_data.error_value <= last_error;
    end
  end

endmodule

[rtl/core/clpc_checker.sv]
`include "calibrated_levitation_p_controller_assert.svh"

module clpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input clpc_pkg::out_item_t             result_data
);

  logic [1:0] outstanding;
  logic       seen_lev;
  logic       req_take;
  logic       res_take;

  assign req_take = cmd_valid && cmd_ready;
  assign res_take = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      seen_lev    <= 1'b0;
    end else begin
      outstanding <= outstanding + 2'(req_take) - 2'(res_take);
      if (res_take && result_data.levitating) begin
        seen_lev <= 1'b1;
      end
    end
  end

  `CLPC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))
  `CLPC_ASSERT_SAME(a_result_has_request, result_valid, outstanding != 2'd0)
  `CLPC_ASSERT_SAME(a_accept_limit, req_take, outstanding != 2'd2 && outstanding != 2'd3)
  `CLPC_ASSERT_SAME(a_levitate_sticks, result_valid && seen_lev, result_data.levitating)
  `CLPC_ASSERT_SAME(a_error_zero_cal, result_valid && !result_data.levitating, result_data.error_value == 12'sd0)

endmodule

bind calibrated_levitation_p_controller clpc_checker u_clpc_checker (.*);
